/* rtl/uds_pkg.sv */
// package with payload types, codes and constants of the uds client engine
`default_nettype none
package uds_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [63:0] now_us;
  } uds_in_t;

  typedef struct packed {
    logic [3:0]  result_code;
    logic [2:0]  client_state;
    logic [7:0]  negative_code;
    logic [6:0]  session_type;
    logic [7:0]  reply_sid;
    logic [11:0] response_data_length;
  } uds_out_t;

  typedef enum logic [1:0] {
    KIND_REQ   = 2'd0,
    KIND_RSP   = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_RESET = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_WAIT = 3'd1,
    PH_PEND = 3'd2,
    PH_DONE = 3'd3,
    PH_FAIL = 3'd4
  } phase_e;

  typedef enum logic [3:0] {
    R_OK          = 4'd0,
    R_COMPLETE    = 4'd1,
    R_WAITING     = 4'd2,
    R_PENDING     = 4'd3,
    R_NEGATIVE    = 4'd4,
    R_INVALID     = 4'd5,
    R_MALFORMED   = 4'd6,
    R_UNEXPECTED  = 4'd7,
    R_BUSY        = 4'd8,
    R_TIMEOUT     = 4'd9,
    R_FAILED      = 4'd10,
    R_UNSUPPORTED = 4'd11
  } result_e;

  typedef enum logic [0:0] {
    CFG_RSP_TIMEOUT  = 1'b0,
    CFG_PEND_TIMEOUT = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] SVC_SESSION = 8'h10;
  localparam logic [7:0] SVC_TESTER  = 8'h3e;
  localparam logic [7:0] SVC_RDBI    = 8'h22;
  localparam logic [7:0] SVC_NEG     = 8'h7f;
  localparam logic [7:0] SVC_MAX     = 8'hbf;
  localparam logic [7:0] POS_OFFSET  = 8'h40;
  localparam logic [7:0] NRC_PENDING = 8'h78;
  localparam logic [31:0] P2_SCALE   = 32'd1000;
  localparam logic [31:0] P2S_SCALE  = 32'd10000;
  localparam logic [31:0] RSP_TIMEOUT_RST  = 32'd50000;
  localparam logic [31:0] PEND_TIMEOUT_RST = 32'd5000000;

endpackage
`default_nettype wire

/* rtl/uds_pdu_asm.sv */
// pdu assembler: byte count, first byte and captured bytes per transaction
`default_nettype none
module uds_pdu_asm #(
  parameter int unsigned MaxPduBytes = 4095
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire uds_pkg::uds_in_t           in_i,
  output logic [$clog2(MaxPduBytes+1)-1:0] cnt_o,
  output logic [7:0]                      first_o,
  output logic [4:0][7:0]                 cap_o
);
  import uds_pkg::*;

  localparam int unsigned CW = $clog2(MaxPduBytes + 1);
  localparam logic [CW-1:0] CntMax = CW'(MaxPduBytes);

  logic [CW-1:0]   cnt_q, cnt_d, base;
  logic            kind_q;
  logic [7:0]      first_q;
  logic [4:0][7:0] cap_q, cap_d;
  logic [7:0]      first_d;

  always_comb begin
    base = cnt_q;
    if (cnt_q != '0 && kind_q != in_i.kind[0]) base = '0;
    first_d = first_q;
    cap_d   = cap_q;
    if (base == '0) first_d = in_i.data_byte;
    for (int i = 0; i < 5; i++) begin
      if (base == CW'(i + 1)) cap_d[i] = in_i.data_byte;
    end
    cnt_d = (base < CntMax) ? base + CW'(1) : base;
  end

  assign cnt_o   = cnt_d;
  assign first_o = first_d;
  assign cap_o   = cap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      kind_q  <= 1'b0;
      first_q <= '0;
      cap_q   <= '0;
    end else if (en_i) begin
      if (in_i.kind == KIND_RESET) begin
        cnt_q   <= '0;
        first_q <= '0;
        cap_q   <= '0;
      end else if (in_i.kind != KIND_TICK) begin
        kind_q  <= in_i.kind[0];
        first_q <= first_d;
        cap_q   <= cap_d;
        cnt_q   <= in_i.last_byte ? '0 : cnt_d;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/uds_client_transaction_engine_core.sv */
// top level of the uds client transaction engine
// results of tick, reset and pdu-ending transactions are registered into output or skid
// throughput: one input per cycle while the skid is empty, set by single-pass decode
// output register with skid: input stays ready until the skid also holds a result
// reset: asynchronous active low, client idle, timeouts 50000 and 5000000 us
`default_nettype none
module uds_client_transaction_engine_core #(
  parameter int unsigned MAX_PDU_BYTES = 4095
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire uds_pkg::uds_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output uds_pkg::uds_out_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);
  import uds_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PDU_BYTES + 1);

  logic            acc;
  logic [CW-1:0]   cnt;
  logic [7:0]      fb;
  logic [4:0][7:0] d;

  logic [31:0] init_rsp_q, init_pend_q;
  phase_e      ph_q, ph_d;
  result_e     fail_q, fail_d;
  logic [63:0] dl_q, dl_d;
  logic [7:0]  psvc_q, psvc_d, psub_q, psub_d;
  logic [15:0] pid_q, pid_d;
  logic        hsub_q, hsub_d, hid_q, hid_d;
  logic [31:0] rto_q, rto_d, pto_q, pto_d;
  logic [6:0]  sess_q, sess_d;

  logic        emit;
  uds_out_t    res;
  logic        ov_q, sv_q;
  uds_out_t    od_q, sd_q;

  assign in_ready_o  = !sv_q;
  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && in_ready_o;

  uds_pdu_asm #(.MaxPduBytes(MAX_PDU_BYTES)) u_asm (
    .clk_i, .rst_ni, .en_i(acc), .in_i(in_data_i),
    .cnt_o(cnt), .first_o(fb), .cap_o(d)
  );

  logic [64:0] sum_r, sum_p;
  logic [63:0] now;
  logic [15:0] p2, p2s;
  logic [CW-1:0] dlen;
  logic        svc_ok;

  assign now   = in_data_i.now_us;
  assign sum_r = {1'b0, now} + {33'b0, rto_q};
  assign sum_p = {1'b0, now} + {33'b0, pto_q};
  assign p2    = {d[1], d[2]};
  assign p2s   = {d[3], d[4]};
  assign dlen  = cnt - CW'(1);
  assign svc_ok = fb != 8'h00 && fb != SVC_NEG && fb <= SVC_MAX;

  always_comb begin
    ph_d = ph_q; fail_d = fail_q; dl_d = dl_q; psvc_d = psvc_q; psub_d = psub_q;
    pid_d = pid_q; hsub_d = hsub_q; hid_d = hid_q; rto_d = rto_q; pto_d = pto_q;
    sess_d = sess_q;
    emit = 1'b0;
    res = '0;
    res.result_code = R_OK;
    if (in_data_i.kind == KIND_TICK) begin
      emit = 1'b1;
      unique case (ph_q)
        PH_FAIL: res.result_code = fail_q;
        PH_IDLE: res.result_code = R_OK;
        PH_DONE: res.result_code = R_COMPLETE;
        default: begin
          if (now >= dl_q) begin
            ph_d = PH_FAIL; fail_d = R_TIMEOUT; dl_d = '0; res.result_code = R_TIMEOUT;
          end else res.result_code = R_WAITING;
        end
      endcase
    end else if (in_data_i.kind == KIND_RESET) begin
      emit = 1'b1;
      rto_d = init_rsp_q; pto_d = init_pend_q; sess_d = 7'd1; ph_d = PH_IDLE;
      fail_d = R_OK; dl_d = '0; psvc_d = '0; psub_d = '0; pid_d = '0;
      hsub_d = 1'b0; hid_d = 1'b0;
    end else if (in_data_i.last_byte) begin
      emit = 1'b1;
      if (in_data_i.kind == KIND_REQ) begin
        priority if (ph_q == PH_FAIL) res.result_code = R_FAILED;
        else if (ph_q == PH_WAIT || ph_q == PH_PEND) res.result_code = R_BUSY;
        else if (!svc_ok) res.result_code = R_INVALID;
        else begin
          dl_d = '0; psvc_d = '0; psub_d = '0; pid_d = '0; hsub_d = 1'b0; hid_d = 1'b0;
          res.result_code = R_OK;
          if (fb == SVC_SESSION) begin
            priority if (cnt != CW'(2)) res.result_code = R_MALFORMED;
            else if (d[0][7]) res.result_code = R_UNSUPPORTED;
            else if (d[0][6:0] == 7'd0) res.result_code = R_MALFORMED;
            else begin hsub_d = 1'b1; psub_d = {1'b0, d[0][6:0]}; end
          end else if (fb == SVC_TESTER) begin
            priority if (cnt != CW'(2)) res.result_code = R_MALFORMED;
            else if (d[0][7]) res.result_code = R_UNSUPPORTED;
            else if (d[0] != 8'h00) res.result_code = R_MALFORMED;
            else hsub_d = 1'b1;
          end else if (fb == SVC_RDBI) begin
            if (cnt != CW'(3)) res.result_code = R_UNSUPPORTED;
            else begin hid_d = 1'b1; pid_d = {d[0], d[1]}; end
          end
          if (res.result_code == R_OK) begin
            psvc_d = fb;
            dl_d = sum_r[64] ? '1 : sum_r[63:0];
            ph_d = PH_WAIT; fail_d = R_OK;
          end
        end
      end else begin
        result_e f;
        f = R_OK;
        priority if (ph_q == PH_FAIL) res.result_code = R_FAILED;
        else if (ph_q != PH_WAIT && ph_q != PH_PEND) res.result_code = R_UNEXPECTED;
        else if (now >= dl_q) f = R_TIMEOUT;
        else if (fb == SVC_NEG) begin
          priority if (cnt != CW'(3) || d[1] == 8'h00) f = R_MALFORMED;
          else if (d[0] != psvc_q) f = R_UNEXPECTED;
          else begin
            res.negative_code = d[1]; res.reply_sid = SVC_NEG;
            if (d[1] == NRC_PENDING) begin
              dl_d = sum_p[64] ? '1 : sum_p[63:0]; ph_d = PH_PEND;
              res.result_code = R_PENDING;
            end else begin
              ph_d = PH_DONE; dl_d = '0; res.result_code = R_NEGATIVE;
            end
          end
        end else if (fb != psvc_q + POS_OFFSET) f = R_UNEXPECTED;
        else begin
          if (hsub_q && psvc_q == SVC_SESSION) begin
            priority if (dlen != CW'(1) && dlen != CW'(5)) f = R_MALFORMED;
            else if (d[0] != psub_q) f = R_UNEXPECTED;
            else if (dlen == CW'(5) && (p2 == 16'd0 || p2s == 16'd0)) f = R_MALFORMED;
            else begin
              sess_d = d[0][6:0];
              if (dlen == CW'(5)) begin
                rto_d = 32'(p2 * P2_SCALE);
                pto_d = 32'(p2s * P2S_SCALE);
              end
            end
          end else if (hsub_q && psvc_q == SVC_TESTER) begin
            priority if (dlen != CW'(1)) f = R_MALFORMED;
            else if (d[0] != 8'h00) f = R_UNEXPECTED;
            else f = R_OK;
          end else if (hid_q && psvc_q == SVC_RDBI) begin
            priority if (dlen < CW'(2)) f = R_MALFORMED;
            else if ({d[0], d[1]} != pid_q) f = R_UNEXPECTED;
            else f = R_OK;
          end
          if (f == R_OK) begin
            res.reply_sid = fb;
            res.response_data_length = (dlen > CW'(4095)) ? 12'd4095 : 12'(dlen);
            ph_d = PH_DONE; dl_d = '0; res.result_code = R_COMPLETE;
          end
        end
        if (f != R_OK) begin
          sess_d = sess_q; rto_d = rto_q; pto_d = pto_q;
          ph_d = PH_FAIL; fail_d = f; dl_d = '0; res.result_code = f;
          res.negative_code = '0; res.reply_sid = '0;
          res.response_data_length = '0;
        end
      end
    end
    res.client_state = ph_d;
    res.session_type = sess_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_rsp_q <= RSP_TIMEOUT_RST; init_pend_q <= PEND_TIMEOUT_RST;
      ph_q <= PH_IDLE; fail_q <= R_OK; dl_q <= '0; psvc_q <= '0; psub_q <= '0;
      pid_q <= '0; hsub_q <= 1'b0; hid_q <= 1'b0;
      rto_q <= RSP_TIMEOUT_RST; pto_q <= PEND_TIMEOUT_RST; sess_q <= 7'd1;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_RSP_TIMEOUT:  init_rsp_q  <= cfg_data_i;
          CFG_PEND_TIMEOUT: init_pend_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc) begin
        ph_q <= ph_d; fail_q <= fail_d; dl_q <= dl_d; psvc_q <= psvc_d;
        psub_q <= psub_d; pid_q <= pid_d; hsub_q <= hsub_d; hid_q <= hid_d;
        rto_q <= rto_d; pto_q <= pto_d; sess_q <= sess_d;
      end
    end
  end

  // output register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sv_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) begin
        ov_q <= sv_q || (acc && emit);
        sv_q <= 1'b0;
      end else if (acc && emit) begin
        if (ov_q) sv_q <= 1'b1;
        else ov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ov_q && out_ready_i) begin
      od_q <= sv_q ? sd_q : res;
    end else if (acc && emit) begin
      if (ov_q) sd_q <= res;
      else od_q <= res;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
endmodule
`default_nettype wire

/* rtl/uds_checker.sv */
// port checker for the uds client engine and its bind
`default_nettype none
module uds_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire uds_pkg::uds_out_t out_data_o
);
  import uds_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o)) else $error("out hold");
  a_stall_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("ready while empty");
  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.client_state <= PH_FAIL &&
    out_data_o.result_code <= R_UNSUPPORTED)
    else $error("code range");
  a_session: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.session_type != 7'd0) else $error("session zero");
endmodule

bind uds_client_transaction_engine_core uds_checker u_chk (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
